// ===== hw/rtl/pes_header_parse_unit_macros.svh =====
// ----------------------------------------------------------------------------
// PES header parse unit assertion macros
// Shared concurrent assertion helpers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PES_HEADER_PARSE_UNIT_MACROS_SVH
`define PES_HEADER_PARSE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PHU_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication failed");
`define PHU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PHU_ASSERT_IMPLY(label, ante, cons)
`define PHU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/phu_pkg.sv =====
// ----------------------------------------------------------------------------
// PES header parse unit package
// Types, phase codes and helper functions shared by the unit.
// ----------------------------------------------------------------------------
package phu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [16:0] MAX_BUFFER_BYTES = 17'd65535;
    localparam logic [32:0] TS_ONES = 33'h1_FFFF_FFFF;
    localparam logic [8:0]  SHORT_OFFSET = 9'd6;
    localparam logic [7:0]  SID_PADDING = 8'hBE;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_HDR_LONG  = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    typedef enum logic [25:0] {
        PH_SC0      = 26'b1 << 0,
        PH_SC1      = 26'b1 << 1,
        PH_SC2      = 26'b1 << 2,
        PH_SID      = 26'b1 << 3,
        PH_LEN0     = 26'b1 << 4,
        PH_LEN1     = 26'b1 << 5,
        PH_FA       = 26'b1 << 6,
        PH_FB       = 26'b1 << 7,
        PH_HDL      = 26'b1 << 8,
        PH_PTS      = 26'b1 << 9,
        PH_DTS      = 26'b1 << 10,
        PH_ESCR     = 26'b1 << 11,
        PH_RATE     = 26'b1 << 12,
        PH_TRICK    = 26'b1 << 13,
        PH_COPY     = 26'b1 << 14,
        PH_CRC      = 26'b1 << 15,
        PH_EXT      = 26'b1 << 16,
        PH_PRIV     = 26'b1 << 17,
        PH_PACKLEN  = 26'b1 << 18,
        PH_PACK     = 26'b1 << 19,
        PH_SEQ      = 26'b1 << 20,
        PH_PSTD     = 26'b1 << 21,
        PH_EXT2LEN  = 26'b1 << 22,
        PH_EXT2     = 26'b1 << 23,
        PH_STUFF    = 26'b1 << 24,
        PH_DONE     = 26'b1 << 25
    } phase_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] payload_size;
        logic [15:0] data_size;
        logic [8:0]  payload_offset;
        logic [8:0]  escr_ext;
        logic [32:0] escr_time;
        logic [32:0] dts;
        logic [32:0] pts;
        logic [7:0]  flags_b;
        logic [7:0]  flags_a;
        logic [15:0] packet_length;
        logic [7:0]  pes_id;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] skip;
    } enter_t;

    localparam phase_t FIELD_SEQ [16] = '{
        PH_PTS, PH_DTS, PH_ESCR, PH_RATE, PH_TRICK, PH_COPY, PH_CRC, PH_EXT,
        PH_PRIV, PH_PACKLEN, PH_PACK, PH_SEQ, PH_PSTD, PH_EXT2LEN, PH_EXT2, PH_STUFF
    };

    function automatic logic [32:0] stamp40(input logic [39:0] v);
        return {v[35:33], v[31:17], v[15:1]};
    endfunction

    function automatic logic is_short_id(input logic [7:0] s);
        return (s == 8'hBC) || (s == 8'hBF) || (s == 8'hF0) || (s == 8'hF1) ||
               (s == 8'hF2) || (s == 8'hF8) || (s == 8'hFF);
    endfunction

    function automatic logic [4:0] field_index(input phase_t p);
        logic [4:0] r;
        r = 5'd16;
        for (int i = 0; i < 16; i++) begin
            if (FIELD_SEQ[i] == p) r = 5'(i);
        end
        return r;
    endfunction

    function automatic enter_t enter_f(input logic [4:0] start, input logic [7:0] fb,
                                       input logic [4:0] ef, input logic [7:0] varlen,
                                       input logic [15:0] cnt, input logic [7:0] hdl);
        logic       en  [16];
        logic [8:0] len [16];
        logic [16:0] hdr_end;
        logic       found;
        enter_t     r;
        hdr_end = 17'd9 + 17'(hdl);
        en[0]  = fb[7]; len[0]  = 9'd5;
        en[1]  = fb[6]; len[1]  = 9'd5;
        en[2]  = fb[5]; len[2]  = 9'd6;
        en[3]  = fb[4]; len[3]  = 9'd3;
        en[4]  = fb[3]; len[4]  = 9'd1;
        en[5]  = fb[2]; len[5]  = 9'd1;
        en[6]  = fb[1]; len[6]  = 9'd2;
        en[7]  = fb[0]; len[7]  = 9'd1;
        en[8]  = ef[4]; len[8]  = 9'd16;
        en[9]  = ef[3]; len[9]  = 9'd1;
        en[10] = ef[3]; len[10] = 9'(varlen);
        en[11] = ef[2]; len[11] = 9'd2;
        en[12] = ef[1]; len[12] = 9'd2;
        en[13] = ef[0]; len[13] = 9'd1;
        en[14] = ef[0]; len[14] = 9'(varlen);
        en[15] = 1'b1;
        len[15] = (17'(cnt) < hdr_end) ? 9'(hdr_end - 17'(cnt)) : 9'd0;
        found   = 1'b0;
        r.phase = PH_DONE;
        r.skip  = 9'd0;
        for (int i = 0; i < 16; i++) begin
            if (!found && (5'(i) >= start) && en[i] && (len[i] != 9'd0)) begin
                found   = 1'b1;
                r.phase = FIELD_SEQ[i];
                r.skip  = len[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pes_header_parse_unit.sv =====
// ----------------------------------------------------------------------------
// PES header parse unit
// Parses one PES buffer per frame and returns one header result per frame.
// ----------------------------------------------------------------------------
// Bytes enter at one per clock through a four-beat queue while it has room;
// the parser consumes one byte a cycle and holds only when its result
// register is still full at a frame's last byte. The last byte passes through
// the queue and then the result register before the result beat is presented,
// and the parser may take a new frame's first byte in that same cycle.
module pes_header_parse_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], pes_id[10:3], packet_length[26:11], flags_a[34:27],
    // flags_b[42:35], pts[75:43], dts[108:76], escr_time[141:109],
    // escr_ext[150:142], payload_offset[159:151], data_size[175:160],
    // payload_size[191:176]
    output logic [191:0] m_tdata
);
    import phu_pkg::*;

    byte_item_t in_item, head_item;
    logic       head_valid, take;
    result_t    res;

    assign in_item = '{last: s_tlast, data: s_tdata};

    phu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (in_item),
        .not_full  (s_tready),
        .pop       (take),
        .head_item (head_item),
        .not_empty (head_valid)
    );

    phu_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (head_valid),
        .item       (head_item),
        .item_take  (take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = res;
endmodule

// ===== hw/rtl/phu_queue.sv =====
// ----------------------------------------------------------------------------
// PES header parse unit front queue
// Accepts byte beats and buffers them ahead of the parser.
// ----------------------------------------------------------------------------
`include "pes_header_parse_unit_macros.svh"
module phu_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  phu_pkg::byte_item_t push_item,
    output logic               not_full,
    input  logic               pop,
    output phu_pkg::byte_item_t head_item,
    output logic               not_empty
);
    import phu_pkg::*;

    byte_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign not_full  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wptr_reg] <= push_item;
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `PHU_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
    `PHU_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
endmodule

// ===== hw/rtl/phu_parse.sv =====
// ----------------------------------------------------------------------------
// PES header parse unit back end, which registers the result at the last byte
// Walks the header one byte a cycle; a full result holds back the last byte.
// ----------------------------------------------------------------------------
`include "pes_header_parse_unit_macros.svh"
module phu_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  phu_pkg::byte_item_t item,
    output logic                item_take,
    output logic                res_valid,
    output phu_pkg::result_t    res,
    input  logic                res_ready
);
    import phu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [47:0] fs_reg, fs_next, fs_shift;
    logic [8:0]  skip_reg, skip_next, skip_dec;
    logic [7:0]  hdl_reg, hdl_next;
    logic [4:0]  ef_reg, ef_next;
    logic [2:0]  err_reg, err_next;
    logic [32:0] pts_reg, pts_next, dts_reg, dts_next, escr_reg, escr_next;
    logic [8:0]  ext_reg, ext_next;
    logic [7:0]  sid_reg, sid_next, fa_reg, fa_next, fb_reg, fb_next;
    logic [15:0] plen_reg, plen_next;
    logic        long_reg, long_next;
    logic        out_valid_reg;
    result_t     out_reg, out_next;
    enter_t      ent;
    logic        do_enter;
    logic [7:0]  b;
    logic [8:0]  off;
    logic [15:0] total;
    logic        field_ph;

    assign item_take = item_valid && (!item.last || !out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign b         = item.data;
    assign fs_shift  = {fs_reg[39:0], b};
    assign skip_dec  = (skip_reg != 9'd0) ? skip_reg - 1'b1 : 9'd0;

    always_comb begin
        cnt_next  = cnt_reg + {15'd0, (cnt_reg != 16'hFFFF)};
        phase_next = phase_reg;
        fs_next   = fs_reg;
        skip_next = skip_reg;
        hdl_next  = hdl_reg;
        ef_next   = ef_reg;
        err_next  = err_reg;
        pts_next  = pts_reg;
        dts_next  = dts_reg;
        escr_next = escr_reg;
        ext_next  = ext_reg;
        sid_next  = sid_reg;
        fa_next   = fa_reg;
        fb_next   = fb_reg;
        plen_next = plen_reg;
        long_next = long_reg;
        do_enter  = 1'b0;
        ent       = '{phase: PH_DONE, skip: 9'd0};
        if (err_reg == ST_OK) begin
            case (phase_reg)
                PH_SC0: begin
                    if (b != 8'h00) err_next = ST_BAD_START; else phase_next = PH_SC1;
                end
                PH_SC1: begin
                    if (b != 8'h00) err_next = ST_BAD_START; else phase_next = PH_SC2;
                end
                PH_SC2: begin
                    if (b != 8'h01) err_next = ST_BAD_START; else phase_next = PH_SID;
                end
                PH_SID: begin
                    sid_next = b;
                    phase_next = PH_LEN0;
                end
                PH_LEN0: begin
                    plen_next = {b, 8'h00};
                    phase_next = PH_LEN1;
                end
                PH_LEN1: begin
                    plen_next = {plen_reg[15:8], b};
                    if (is_short_id(sid_reg)) begin
                        pts_next = TS_ONES;
                        dts_next = TS_ONES;
                        phase_next = PH_DONE;
                    end else if (sid_reg == SID_PADDING) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_FA;
                    end
                end
                PH_FA: begin
                    fa_next = b;
                    phase_next = PH_FB;
                end
                PH_FB: begin
                    fb_next = b;
                    phase_next = PH_HDL;
                end
                PH_HDL: begin
                    hdl_next  = b;
                    long_next = 1'b1;
                    do_enter  = 1'b1;
                    ent = enter_f(5'd0, fb_reg, ef_reg, 8'd0, cnt_next, b);
                end
                PH_DONE: begin
                end
                default: begin
                    if (17'(cnt_reg) >= 17'd9 + 17'(hdl_reg)) begin
                        err_next = ST_OVERRUN;
                    end else begin
                        fs_next   = fs_shift;
                        skip_next = skip_dec;
                        if (skip_dec == 9'd0) begin
                            do_enter = 1'b1;
                            case (phase_reg)
                                PH_PTS: begin
                                    pts_next = stamp40(fs_shift[39:0]);
                                    ent = enter_f(5'd1, fb_reg, ef_reg, 8'd0, cnt_next, hdl_reg);
                                end
                                PH_DTS: begin
                                    dts_next = stamp40(fs_shift[39:0]);
                                    ent = enter_f(5'd2, fb_reg, ef_reg, 8'd0, cnt_next, hdl_reg);
                                end
                                PH_ESCR: begin
                                    escr_next = {fs_shift[45:43], fs_shift[41:27],
                                                 fs_shift[25:11]};
                                    ext_next  = fs_shift[9:1];
                                    ent = enter_f(5'd3, fb_reg, ef_reg, 8'd0, cnt_next, hdl_reg);
                                end
                                PH_EXT: begin
                                    ef_next = {b[7:4], b[0]};
                                    ent = enter_f(5'd8, fb_reg, {b[7:4], b[0]}, 8'd0,
                                                  cnt_next, hdl_reg);
                                end
                                PH_PACKLEN: begin
                                    ent = enter_f(5'd10, fb_reg, ef_reg, b, cnt_next, hdl_reg);
                                end
                                PH_EXT2LEN: begin
                                    ent = enter_f(5'd14, fb_reg, ef_reg, {1'b0, b[6:0]},
                                                  cnt_next, hdl_reg);
                                end
                                PH_STUFF: begin
                                    ent = '{phase: PH_DONE, skip: 9'd0};
                                end
                                default: begin
                                    ent = enter_f(field_index(phase_reg) + 5'd1, fb_reg,
                                                  ef_reg, 8'd0, cnt_next, hdl_reg);
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
        if (do_enter) begin
            phase_next = ent.phase;
            skip_next  = ent.skip;
            fs_next    = '0;
        end
    end

    assign field_ph = (phase_next != PH_DONE) && (field_index(phase_next) != 5'd16);
    assign off      = long_next ? 9'd9 + 9'(hdl_next) : SHORT_OFFSET;
    assign total    = (17'(cnt_next) < MAX_BUFFER_BYTES) ? cnt_next : MAX_BUFFER_BYTES[15:0];

    always_comb begin
        out_next = '0;
        out_next.pes_id        = sid_next;
        out_next.packet_length = plen_next;
        out_next.flags_a       = fa_next;
        out_next.flags_b       = fb_next;
        out_next.pts           = pts_next;
        out_next.dts           = dts_next;
        out_next.escr_time     = escr_next;
        out_next.escr_ext      = ext_next;
        if (err_next != ST_OK) begin
            out_next.status = err_next;
        end else if (phase_next != PH_DONE) begin
            out_next.status = (field_ph && (16'(hdl_next) > cnt_next)) ? ST_HDR_LONG : ST_SHORT;
        end else begin
            out_next.status         = ST_OK;
            out_next.payload_offset = off;
            out_next.data_size      = (total >= 16'(off)) ? total - 16'(off) : 16'd0;
            out_next.payload_size   = ((sid_next == SID_PADDING) || (plen_next == 16'd0)) ?
                                      16'd0 : plen_next - 16'(off - SHORT_OFFSET);
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && item.last) out_reg <= out_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg <= PH_SC0;
            cnt_reg   <= '0;
            fs_reg    <= '0;
            skip_reg  <= '0;
            hdl_reg   <= '0;
            ef_reg    <= '0;
            err_reg   <= ST_OK;
            pts_reg   <= '0;
            dts_reg   <= '0;
            escr_reg  <= '0;
            ext_reg   <= '0;
            sid_reg   <= '0;
            fa_reg    <= '0;
            fb_reg    <= '0;
            plen_reg  <= '0;
            long_reg  <= 1'b0;
        end else begin
            if (item_take && item.last) out_valid_reg <= 1'b1;
            else if (res_ready)          out_valid_reg <= 1'b0;
            if (item_take) begin
                if (item.last) begin
                    phase_reg <= PH_SC0;
                    cnt_reg   <= '0;
                    fs_reg    <= '0;
                    skip_reg  <= '0;
                    hdl_reg   <= '0;
                    ef_reg    <= '0;
                    err_reg   <= ST_OK;
                    pts_reg   <= '0;
                    dts_reg   <= '0;
                    escr_reg  <= '0;
                    ext_reg   <= '0;
                    sid_reg   <= '0;
                    fa_reg    <= '0;
                    fb_reg    <= '0;
                    plen_reg  <= '0;
                    long_reg  <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    cnt_reg   <= cnt_next;
                    fs_reg    <= fs_next;
                    skip_reg  <= skip_next;
                    hdl_reg   <= hdl_next;
                    ef_reg    <= ef_next;
                    err_reg   <= err_next;
                    pts_reg   <= pts_next;
                    dts_reg   <= dts_next;
                    escr_reg  <= escr_next;
                    ext_reg   <= ext_next;
                    sid_reg   <= sid_next;
                    fa_reg    <= fa_next;
                    fb_reg    <= fb_next;
                    plen_reg  <= plen_next;
                    long_reg  <= long_next;
                end
            end
        end
    end

    `PHU_ASSERT_NEXT(a_last_gives_result, item_take && item.last, out_valid_reg)
    `PHU_ASSERT_NEXT(a_error_sticks, item_take && !item.last && (err_reg != ST_OK), err_reg != ST_OK)
endmodule
